// ===== src/cubv_pkg.sv =====
package cubv_pkg;

    localparam int TW    = 24;  // period and time width, Q8.16
    localparam int PSW   = 18;  // position width, Q4.14
    localparam int VSW   = 20;  // velocity input width, Q4.16
    localparam int JW    = 3;   // joint index width
    localparam int CMW   = 2;   // command width
    localparam int CW    = 28;  // signed coefficient width
    localparam int QW    = 2 * TW;
    localparam int CUW   = 3 * TW;
    localparam int NW    = 100; // signed numerator width
    localparam int MW    = NW - 1;
    localparam int QBITS = 24;  // quotient bits below the overflow point
    localparam int JVW   = 24;  // joint velocity width
    localparam int SPW   = 32;  // motor speed width
    localparam int GW    = 28;  // gear factor width, unsigned Q.16
    localparam int CSH   = 16;  // coefficient scale shift

    localparam int JOINT_COUNT_DEF = 6;

    localparam logic [TW-1:0] POINT_PERIOD_RST = 24'd327680;
    localparam logic [TW-1:0] VIA_PERIOD_RST   = 24'd95683;

    localparam logic [QBITS:0] VEL_POS_LIM = 25'h07F_FFFF;
    localparam logic [QBITS:0] VEL_NEG_LIM = 25'h080_0000;

    localparam logic REG_POINT = 1'b0;
    localparam logic REG_VIA   = 1'b1;

    typedef enum logic [CMW-1:0] {
        CMD_P2P  = 2'd0,
        CMD_VIA1 = 2'd1,
        CMD_VIA2 = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic signed [CW-1:0] den;
        logic signed [CW-1:0] p2;
        logic signed [CW-1:0] tp;
        logic signed [CW-1:0] tt;
        logic signed [CW-1:0] tpp;
        logic signed [CW-1:0] ttp;
    } t_coef;

    typedef struct packed {
        logic          zero;
        logic [JW-1:0] joint;
        t_coef         coef;
        logic [QW-1:0]  p2;
        logic [QW-1:0]  tp;
        logic [QW-1:0]  t2;
        logic [CUW-1:0] den;
        logic [CUW-1:0] tpp;
        logic [CUW-1:0] ttp;
    } t_front;

    typedef struct packed {
        logic           zero;
        logic [JW-1:0]  joint;
        logic           neg;
        logic [MW-1:0]  mag;
        logic [CUW-1:0] den;
    } t_mag;

    typedef struct packed {
        logic          zero;
        logic [JW-1:0] joint;
        logic          neg;
        logic          ovf;
        logic [QBITS:0] q;
    } t_quo;

    function automatic logic [GW-1:0] gear_q16(input logic [JW-1:0] j);
        logic [GW-1:0] g;
        case (j)
            3'd0:    g = 28'd112648086;
            3'd1:    g = 28'd256587307;
            3'd2:    g = 28'd187746810;
            3'd3:    g = 28'd234683513;
            3'd4:    g = 28'd234683513;
            3'd5:    g = 28'd83443027;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== src/cubv_front.sv =====
module cubv_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [cubv_pkg::CMW-1:0]    i_command,
    input  logic [cubv_pkg::JW-1:0]     i_joint,
    input  logic signed [cubv_pkg::PSW-1:0] i_start_pos,
    input  logic signed [cubv_pkg::PSW-1:0] i_mid_pos,
    input  logic signed [cubv_pkg::PSW-1:0] i_end_pos,
    input  logic signed [cubv_pkg::VSW-1:0] i_start_vel,
    input  logic signed [cubv_pkg::VSW-1:0] i_end_vel,
    input  logic [cubv_pkg::TW-1:0]     i_time_req,
    input  logic [cubv_pkg::TW-1:0]     i_point_period,
    input  logic [cubv_pkg::TW-1:0]     i_via_period,
    output logic                        o_vld,
    output cubv_pkg::t_front            o_data
);
    import cubv_pkg::*;

    logic [3:0] r_vld;

    t_cmd                 cmd;
    logic signed [CW-1:0] pi0, pm, pf, v0, vf;
    logic signed [CW-1:0] dp, ca, cb, cc, ce;
    logic [TW-1:0]        n_per;
    t_coef                n_coef;
    logic                 n_zero;

    logic [TW-1:0]  r1_per, r1_t;
    t_coef          r1_coef;
    logic           r1_zero;
    logic [JW-1:0]  r1_joint;

    logic [TW-1:0]  r2_per;
    logic [QW-1:0]  r2_p2, r2_tp, r2_t2;
    t_coef          r2_coef;
    logic           r2_zero;
    logic [JW-1:0]  r2_joint;

    logic [QW-1:0]  r3_p2, r3_tp, r3_t2;
    logic [QW-1:0]  r3_den_lo, r3_den_hi, r3_tpp_lo, r3_tpp_hi, r3_ttp_lo, r3_ttp_hi;
    t_coef          r3_coef;
    logic           r3_zero;
    logic [JW-1:0]  r3_joint;

    t_front         r4_out;

    assign cmd = t_cmd'(i_command);
    assign pi0 = CW'(i_start_pos);
    assign pm  = CW'(i_mid_pos);
    assign pf  = CW'(i_end_pos);
    assign v0  = CW'(i_start_vel);
    assign vf  = CW'(i_end_vel);
    assign dp  = pf - pi0;
    assign ca  = 28'sd12 * pm - 28'sd3 * pf - 28'sd9 * pi0;
    assign cb  = 28'sd5 * pi0 + 28'sd3 * pf - 28'sd8 * pm;
    assign cc  = 28'sd6 * pf + 28'sd6 * pi0 - 28'sd12 * pm;
    assign ce  = 28'sd8 * pm - 28'sd5 * pf - 28'sd3 * pi0;

    always_comb begin
        n_per = (cmd == CMD_P2P) ? i_point_period : i_via_period;
        if (n_per == '0) begin
            n_per = TW'(1);
        end
        n_coef = '0;
        n_zero = 1'b0;
        case (cmd)
            CMD_P2P: begin
                n_coef.den = v0;
                n_coef.tp  = 28'sd24 * dp;
                n_coef.tt  = -(28'sd24 * dp);
                n_coef.tpp = -(28'sd4 * v0 + 28'sd2 * vf);
                n_coef.ttp = 28'sd3 * (v0 + vf);
            end
            CMD_VIA1: begin
                n_coef.tp = 28'sd8 * ca;
                n_coef.tt = 28'sd24 * cb;
            end
            CMD_VIA2: begin
                n_coef.p2 = 28'sd6 * dp;
                n_coef.tp = 28'sd8 * cc;
                n_coef.tt = 28'sd24 * ce;
            end
            default: begin
                n_zero = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_per   <= n_per;
            r1_t     <= i_time_req;
            r1_coef  <= n_coef;
            r1_zero  <= n_zero;
            r1_joint <= i_joint;

            r2_per   <= r1_per;
            r2_p2    <= QW'(r1_per) * QW'(r1_per);
            r2_tp    <= QW'(r1_t) * QW'(r1_per);
            r2_t2    <= QW'(r1_t) * QW'(r1_t);
            r2_coef  <= r1_coef;
            r2_zero  <= r1_zero;
            r2_joint <= r1_joint;

            // 48 by 24 products as two 24 by 24 halves
            r3_den_lo <= QW'(r2_p2[TW-1:0])  * QW'(r2_per);
            r3_den_hi <= QW'(r2_p2[QW-1:TW]) * QW'(r2_per);
            r3_tpp_lo <= QW'(r2_tp[TW-1:0])  * QW'(r2_per);
            r3_tpp_hi <= QW'(r2_tp[QW-1:TW]) * QW'(r2_per);
            r3_ttp_lo <= QW'(r2_t2[TW-1:0])  * QW'(r2_per);
            r3_ttp_hi <= QW'(r2_t2[QW-1:TW]) * QW'(r2_per);
            r3_p2     <= r2_p2;
            r3_tp     <= r2_tp;
            r3_t2     <= r2_t2;
            r3_coef   <= r2_coef;
            r3_zero   <= r2_zero;
            r3_joint  <= r2_joint;

            r4_out.zero  <= r3_zero;
            r4_out.joint <= r3_joint;
            r4_out.coef  <= r3_coef;
            r4_out.p2    <= r3_p2;
            r4_out.tp    <= r3_tp;
            r4_out.t2    <= r3_t2;
            r4_out.den   <= CUW'(r3_den_lo) + (CUW'(r3_den_hi) << TW);
            r4_out.tpp   <= CUW'(r3_tpp_lo) + (CUW'(r3_tpp_hi) << TW);
            r4_out.ttp   <= CUW'(r3_ttp_lo) + (CUW'(r3_ttp_hi) << TW);
        end
    end

    assign o_vld  = r_vld[3];
    assign o_data = r4_out;

endmodule

// ===== src/cubv_poly.sv =====
module cubv_poly (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  cubv_pkg::t_front i_data,
    output logic             o_vld,
    output cubv_pkg::t_mag   o_data
);
    import cubv_pkg::*;

    localparam int PPW = CW + TW + 1;

    function automatic logic signed [PPW-1:0] mulc(input logic signed [CW-1:0] c,
                                                   input logic [TW-1:0] x);
        return PPW'(c) * PPW'($signed({1'b0, x}));
    endfunction

    function automatic logic signed [NW-1:0] sum2(input logic signed [PPW-1:0] a,
                                                  input logic signed [PPW-1:0] b);
        return NW'(a) + (NW'(b) <<< TW);
    endfunction

    function automatic logic signed [NW-1:0] sum3(input logic signed [PPW-1:0] a,
                                                  input logic signed [PPW-1:0] b,
                                                  input logic signed [PPW-1:0] c);
        return NW'(a) + (NW'(b) <<< TW) + (NW'(c) <<< (2 * TW));
    endfunction

    logic [4:0] r_vld;

    logic signed [PPW-1:0] r5_p2 [2];
    logic signed [PPW-1:0] r5_tp [2];
    logic signed [PPW-1:0] r5_tt [2];
    logic signed [PPW-1:0] r5_den [3];
    logic signed [PPW-1:0] r5_tpp [3];
    logic signed [PPW-1:0] r5_ttp [3];
    logic signed [NW-1:0]  r6_term [6];
    logic signed [NW-1:0]  r7_sum [3];
    logic signed [NW-1:0]  r8_num;
    logic [CUW-1:0]        r5_dv, r6_dv, r7_dv, r8_dv;
    logic                  r5_zero, r6_zero, r7_zero, r8_zero;
    logic [JW-1:0]         r5_joint, r6_joint, r7_joint, r8_joint;
    t_mag                  r9_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // coefficient times 24-bit slices of each product
            r5_p2[0]  <= mulc(i_data.coef.p2,  i_data.p2[TW-1:0]);
            r5_p2[1]  <= mulc(i_data.coef.p2,  i_data.p2[QW-1:TW]);
            r5_tp[0]  <= mulc(i_data.coef.tp,  i_data.tp[TW-1:0]);
            r5_tp[1]  <= mulc(i_data.coef.tp,  i_data.tp[QW-1:TW]);
            r5_tt[0]  <= mulc(i_data.coef.tt,  i_data.t2[TW-1:0]);
            r5_tt[1]  <= mulc(i_data.coef.tt,  i_data.t2[QW-1:TW]);
            r5_den[0] <= mulc(i_data.coef.den, i_data.den[TW-1:0]);
            r5_den[1] <= mulc(i_data.coef.den, i_data.den[QW-1:TW]);
            r5_den[2] <= mulc(i_data.coef.den, i_data.den[CUW-1:QW]);
            r5_tpp[0] <= mulc(i_data.coef.tpp, i_data.tpp[TW-1:0]);
            r5_tpp[1] <= mulc(i_data.coef.tpp, i_data.tpp[QW-1:TW]);
            r5_tpp[2] <= mulc(i_data.coef.tpp, i_data.tpp[CUW-1:QW]);
            r5_ttp[0] <= mulc(i_data.coef.ttp, i_data.ttp[TW-1:0]);
            r5_ttp[1] <= mulc(i_data.coef.ttp, i_data.ttp[QW-1:TW]);
            r5_ttp[2] <= mulc(i_data.coef.ttp, i_data.ttp[CUW-1:QW]);
            r5_dv     <= i_data.den;
            r5_zero   <= i_data.zero;
            r5_joint  <= i_data.joint;

            r6_term[0] <= sum2(r5_p2[0], r5_p2[1]) <<< CSH;
            r6_term[1] <= sum2(r5_tp[0], r5_tp[1]) <<< CSH;
            r6_term[2] <= sum2(r5_tt[0], r5_tt[1]) <<< CSH;
            r6_term[3] <= sum3(r5_den[0], r5_den[1], r5_den[2]);
            r6_term[4] <= sum3(r5_tpp[0], r5_tpp[1], r5_tpp[2]);
            r6_term[5] <= sum3(r5_ttp[0], r5_ttp[1], r5_ttp[2]);
            r6_dv      <= r5_dv;
            r6_zero    <= r5_zero;
            r6_joint   <= r5_joint;

            r7_sum[0] <= r6_term[0] + r6_term[1];
            r7_sum[1] <= r6_term[2] + r6_term[3];
            r7_sum[2] <= r6_term[4] + r6_term[5];
            r7_dv     <= r6_dv;
            r7_zero   <= r6_zero;
            r7_joint  <= r6_joint;

            r8_num   <= r7_sum[0] + r7_sum[1] + r7_sum[2];
            r8_dv    <= r7_dv;
            r8_zero  <= r7_zero;
            r8_joint <= r7_joint;

            r9_out.neg   <= r8_num[NW-1];
            r9_out.mag   <= r8_num[NW-1] ? MW'(-r8_num) : MW'(r8_num);
            r9_out.den   <= r8_dv;
            r9_out.zero  <= r8_zero;
            r9_out.joint <= r8_joint;
        end
    end

    assign o_vld  = r_vld[4];
    assign o_data = r9_out;

endmodule

// ===== src/cubv_div.sv =====
module cubv_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  cubv_pkg::t_mag i_data,
    output logic           o_vld,
    output cubv_pkg::t_quo o_data
);
    import cubv_pkg::*;

    typedef struct packed {
        logic           zero;
        logic [JW-1:0]  joint;
        logic           neg;
        logic           ovf;
        logic [MW-1:0]  rem;
        logic [CUW-1:0] den;
        logic [QBITS-1:0] q;
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st s, input int k);
        logic [MW-1:0] dsh;
        t_div_st       r;
        dsh = MW'(s.den) << k;
        r   = s;
        if (s.rem >= dsh) begin
            r.rem = s.rem - dsh;
            r.q   = s.q | (QBITS'(1) << k);
        end
        return r;
    endfunction

    logic [QBITS+1:0] r_vld;
    t_div_st          r_st [0:QBITS];
    t_quo             r_out;
    logic             rnd_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QBITS:0], i_vld};
        end
    end

    // quotient at or above 2^24 always clips, so only 24 bits are developed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].zero  <= i_data.zero;
            r_st[0].joint <= i_data.joint;
            r_st[0].neg   <= i_data.neg;
            r_st[0].ovf   <= i_data.mag >= (MW'(i_data.den) << QBITS);
            r_st[0].rem   <= i_data.mag;
            r_st[0].den   <= i_data.den;
            r_st[0].q     <= '0;
            for (int g = 0; g < QBITS; g++) begin
                r_st[g+1] <= div_step(r_st[g], QBITS - 1 - g);
            end
        end
    end

    assign rnd_up = {r_st[QBITS].rem, 1'b0} >= (MW+1)'(r_st[QBITS].den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.zero  <= r_st[QBITS].zero;
            r_out.joint <= r_st[QBITS].joint;
            r_out.neg   <= r_st[QBITS].neg;
            r_out.ovf   <= r_st[QBITS].ovf;
            r_out.q     <= (QBITS+1)'(r_st[QBITS].q) + (QBITS+1)'(rnd_up);
        end
    end

    assign o_vld  = r_vld[QBITS+1];
    assign o_data = r_out;

endmodule

// ===== src/cubv_out.sv =====
module cubv_out #(
    parameter int JOINT_COUNT = cubv_pkg::JOINT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  cubv_pkg::t_quo                 i_data,
    output logic                           o_vld,
    output logic signed [cubv_pkg::JVW-1:0] o_joint_velocity,
    output logic signed [cubv_pkg::SPW-1:0] o_motor_speed,
    output logic                           o_saturated
);
    import cubv_pkg::*;

    localparam int PRW = GW + JVW;

    logic [1:0]       r_vld;
    logic [QBITS:0]   lim;
    logic             n_sat;
    logic [JVW-1:0]   qc;
    logic [PRW-1:0]   msum;
    logic [SPW-1:0]   mag_spd;

    logic [JVW-1:0]   ra_vel;
    logic [PRW-1:0]   ra_prod;
    logic             ra_neg, ra_sat, ra_zero, ra_gear;

    logic [JVW-1:0]   r_vel;
    logic [SPW-1:0]   r_spd;
    logic             r_sat;

    always_comb begin
        lim   = i_data.neg ? VEL_NEG_LIM : VEL_POS_LIM;
        n_sat = i_data.ovf || (i_data.q > lim);
        qc    = n_sat ? lim[JVW-1:0] : i_data.q[JVW-1:0];
    end

    assign msum    = ra_prod + (PRW'(1) << (TW - 1));
    assign mag_spd = SPW'(msum[PRW-1:TW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_vel  <= i_data.neg ? -qc : qc;
            ra_prod <= PRW'(qc) * PRW'(gear_q16(i_data.joint));
            ra_neg  <= i_data.neg;
            ra_sat  <= n_sat;
            ra_zero <= i_data.zero;
            ra_gear <= {1'b0, i_data.joint} < (JW+1)'(JOINT_COUNT);

            if (ra_zero) begin
                r_vel <= '0;
                r_spd <= '0;
                r_sat <= 1'b0;
            end else begin
                r_vel <= ra_vel;
                r_sat <= ra_sat;
                if (!ra_gear) begin
                    r_spd <= '0;
                end else begin
                    r_spd <= ra_neg ? -mag_spd : mag_spd;
                end
            end
        end
    end

    assign o_vld            = r_vld[1];
    assign o_joint_velocity = r_vel;
    assign o_motor_speed    = r_spd;
    assign o_saturated      = r_sat;

endmodule

// ===== src/cubic_trajectory_velocity.sv =====
// Cubic trajectory velocity: one joint request in, one joint velocity (Q8.16) and motor
// speed command (Q24.8) out. A new request can be taken every clock cycle while the output
// is not held; each result passes the front end, the polynomial block and then the 24-stage
// restoring divider that divides the cubic's numerator by the cubed period, one quotient
// bit per stage, before the output block. A stalled output holds the whole pipeline. The
// two period registers sit on the APB port at byte addresses 0 (point-to-point) and 4
// (via-point) and should only be written while no request is in flight.
module cubic_trajectory_velocity #(
    parameter int JOINT_COUNT = cubv_pkg::JOINT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cubv_pkg::CMW-1:0]        i_command,
    input  logic [cubv_pkg::JW-1:0]         i_joint,
    input  logic signed [cubv_pkg::PSW-1:0] i_start_pos,
    input  logic signed [cubv_pkg::PSW-1:0] i_mid_pos,
    input  logic signed [cubv_pkg::PSW-1:0] i_end_pos,
    input  logic signed [cubv_pkg::VSW-1:0] i_start_vel,
    input  logic signed [cubv_pkg::VSW-1:0] i_end_vel,
    input  logic [cubv_pkg::TW-1:0]         i_time_req,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [cubv_pkg::JVW-1:0] o_joint_velocity,
    output logic signed [cubv_pkg::SPW-1:0] o_motor_speed,
    output logic                            o_saturated,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cubv_pkg::*;

    logic [TW-1:0] r_point_period, r_via_period;
    logic          adv, cfg_wr;
    logic          front_vld, poly_vld, div_vld;
    t_front        front_data;
    t_mag          poly_data;
    t_quo          div_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_VIA) ? 32'(r_via_period) : 32'(r_point_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_period <= POINT_PERIOD_RST;
            r_via_period   <= VIA_PERIOD_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_POINT) begin
                r_point_period <= pwdata[TW-1:0];
            end else begin
                r_via_period <= pwdata[TW-1:0];
            end
        end
    end

    // whole pipeline moves unless the output word is held
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    cubv_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_vld          (i_valid),
        .i_command      (i_command),
        .i_joint        (i_joint),
        .i_start_pos    (i_start_pos),
        .i_mid_pos      (i_mid_pos),
        .i_end_pos      (i_end_pos),
        .i_start_vel    (i_start_vel),
        .i_end_vel      (i_end_vel),
        .i_time_req     (i_time_req),
        .i_point_period (r_point_period),
        .i_via_period   (r_via_period),
        .o_vld          (front_vld),
        .o_data         (front_data)
    );

    cubv_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (front_vld),
        .i_data  (front_data),
        .o_vld   (poly_vld),
        .o_data  (poly_data)
    );

    cubv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (poly_vld),
        .i_data  (poly_data),
        .o_vld   (div_vld),
        .o_data  (div_data)
    );

    cubv_out #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (adv),
        .i_vld            (div_vld),
        .i_data           (div_data),
        .o_vld            (o_valid),
        .o_joint_velocity (o_joint_velocity),
        .o_motor_speed    (o_motor_speed),
        .o_saturated      (o_saturated)
    );

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
        (o_joint_velocity == 24'sh7F_FFFF || o_joint_velocity == -24'sh80_0000))
        else $error("saturated word not at a velocity limit");

    a_zero_vel_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_joint_velocity == '0) |-> (o_motor_speed == '0))
        else $error("motor speed without joint velocity");

    a_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_motor_speed != '0) |->
        (o_motor_speed[SPW-1] == o_joint_velocity[JVW-1]))
        else $error("motor speed sign differs from joint velocity");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cubv_pkg::*;

    localparam int LATENCY   = 37;
    localparam int WD_LIMIT  = 4000;
    localparam logic [2:0] ADDR_POINT = 3'd0;
    localparam logic [2:0] ADDR_VIA   = 3'd4;

    typedef struct {
        logic signed [JVW-1:0] vel;
        logic signed [SPW-1:0] spd;
        logic                  sat;
    } t_velocity;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [CMW-1:0]        i_command;
    logic [JW-1:0]         i_joint;
    logic signed [PSW-1:0] i_start_pos, i_mid_pos, i_end_pos;
    logic signed [VSW-1:0] i_start_vel, i_end_vel;
    logic [TW-1:0]         i_time_req;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [JVW-1:0] o_joint_velocity;
    logic signed [SPW-1:0] o_motor_speed;
    logic                  o_saturated;
    logic                  psel, penable, pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata, prdata;
    logic                  pready;

    cubic_trajectory_velocity dut (.*);

    logic [TW-1:0] point_per, via_per;
    t_velocity     expected_q[$];
    int            errors;
    int            idle_cycles;
    bit            stall_en;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // exact evaluation of the cubic velocity, rounded once, then gear scaling
    function automatic t_velocity predict_velocity(
        input logic [CMW-1:0] cmd, input logic [JW-1:0] jnt,
        input logic signed [PSW-1:0] p0, pm, pf,
        input logic signed [VSW-1:0] v0, vf, input logic [TW-1:0] tr);
        t_velocity     r;
        logic signed [199:0] num, den, per, t, mag, q, rm, lim;
        logic [63:0]   gear, m;
        logic          neg;
        r.vel = '0; r.spd = '0; r.sat = 1'b0;
        if (cmd == CMD_NONE) return r;
        per = (cmd == CMD_P2P) ? point_per : via_per;
        if (per == 0) per = 1;
        t = tr;
        den = per * per * per;
        if (cmd == CMD_P2P) begin
            num = den * v0
                + 200'(24 * 65536) * (pf - p0) * t * (per - t)
                + (-2 * (2 * 200'(v0) + vf)) * t * per * per
                + (3 * (200'(v0) + vf)) * t * t * per;
        end else if (cmd == CMD_VIA1) begin
            num = 200'(524288) * (12 * 200'(pm) - 3 * pf - 9 * p0) * t * per
                + 200'(24 * 65536) * (-8 * 200'(pm) + 3 * pf + 5 * p0) * t * t;
        end else begin
            num = 200'(6 * 65536) * (200'(pf) - p0) * per * per
                + 200'(524288) * (-12 * 200'(pm) + 6 * pf + 6 * p0) * t * per
                + 200'(24 * 65536) * (8 * 200'(pm) - 5 * pf - 3 * p0) * t * t;
        end
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        rm = mag % den;
        if (2 * rm >= den) q = q + 1;
        lim = neg ? 200'h800000 : 200'h7FFFFF;
        if (q > lim) begin
            q = lim;
            r.sat = 1'b1;
        end
        r.vel = neg ? -q[JVW-1:0] : q[JVW-1:0];
        case (jnt)
            3'd0: gear = 112648086;
            3'd1: gear = 256587307;
            3'd2: gear = 187746810;
            3'd3, 3'd4: gear = 234683513;
            3'd5: gear = 83443027;
            default: gear = 0;
        endcase
        m = (q[63:0] * gear + (64'd1 << 23)) >> 24;
        r.spd = neg ? -m[31:0] : m[31:0];
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic [TW-1:0] val);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = 32'(val);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_POINT) point_per = val;
        else via_per = val;
    endtask

    task automatic send_word(input logic [CMW-1:0] cmd, input logic [JW-1:0] jnt,
        input logic signed [PSW-1:0] p0, pm, pf,
        input logic signed [VSW-1:0] v0, vf, input logic [TW-1:0] tr);
        i_valid = 1'b1; i_command = cmd; i_joint = jnt;
        i_start_pos = p0; i_mid_pos = pm; i_end_pos = pf;
        i_start_vel = v0; i_end_vel = vf; i_time_req = tr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q = {expected_q, predict_velocity(cmd, jnt, p0, pm, pf, v0, vf, tr)};
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_random(input bit realistic);
        logic [CMW-1:0] cmd;
        logic [TW-1:0]  tr;
        logic signed [PSW-1:0] p0, pm, pf;
        cmd = realistic ? CMW'(CMD_P2P + $urandom_range(0, 2)) : CMW'($urandom_range(0, 3));
        p0 = PSW'($urandom); pm = PSW'($urandom); pf = PSW'($urandom);
        tr = TW'($urandom);
        if (realistic) begin
            p0 = PSW'($signed(18'($urandom_range(0, 60000))) - 30000);
            pm = PSW'(p0 + $signed(18'($urandom_range(0, 20000))) - 10000);
            pf = PSW'(p0 + $signed(18'($urandom_range(0, 20000))) - 10000);
            tr = TW'($urandom_range(0, (cmd == CMD_P2P) ? point_per : via_per / 2));
        end
        send_word(cmd, JW'($urandom_range(0, 7)), p0, pm, pf, 20'($urandom), 20'($urandom),
                  tr);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic test_extremes();
        logic signed [PSW-1:0] pv[3];
        pv = '{18'sh20000, 18'sh1FFFF, 18'sd0};
        foreach (pv[k]) begin
            send_word(CMD_P2P, 3'd0, pv[k], -pv[k], -pv[k], 20'sh80000, 20'sh7FFFF, 24'hFFFFFF);
            send_word(CMD_VIA1, 3'd1, pv[k], pv[k], -pv[k], 20'sh7FFFF, 20'sh80000, 24'd0);
            send_word(CMD_VIA2, 3'd5, -pv[k], pv[k], pv[k], 20'sh0, 20'sh0, 24'd47841);
        end
        send_word(CMD_NONE, 3'd2, 18'sd100, 18'sd5, 18'sd7, 20'sd1, 20'sd1, 24'd5);
        for (int j = 0; j < 8; j++)
            send_word(CMD_P2P, 3'(j), 18'sd0, 18'sd0, 18'sd16384, 20'sd0, 20'sd0, 24'd163840);
        send_word(CMD_VIA2, 3'd3, 18'sd0, 18'sd1000, 18'sd0, 20'sd0, 20'sd0, 24'd900000);
        drain();
    endtask

    task automatic test_periods();
        logic [TW-1:0] pp[4];
        pp = '{24'd0, 24'd1, 24'hFFFFFF, 24'd65536};
        foreach (pp[k]) begin
            write_reg(ADDR_POINT, pp[k]);
            write_reg(ADDR_VIA, pp[3 - k]);
            repeat (6) send_random(1'b1);
            repeat (2) send_random(1'b0);
            drain();
        end
        write_reg(ADDR_POINT, POINT_PERIOD_RST);
        write_reg(ADDR_VIA, VIA_PERIOD_RST);
    endtask

    task automatic test_random_traffic();
        int sent;
        sent = 0;
        while (sent < 1250) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                send_random($urandom_range(0, 9) != 0);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            if (sent % 400 < burst) begin
                drain();
                write_reg(ADDR_POINT, 24'($urandom_range(1000, 800000)));
                write_reg(ADDR_VIA, 24'($urandom_range(1000, 800000)));
            end
        end
        drain();
    endtask

    // receiver stalls on its own pattern, with quiet stretches
    always @(negedge i_clk) begin
        if (!stall_en) i_ready <= 1'b1;
        else if ($urandom_range(0, 299) < 4) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0) || (($urandom & 32'h100) != 0);
    end

    always @(posedge i_clk) begin
        t_velocity e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected word", o_joint_velocity, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_joint_velocity !== e.vel) report("joint_velocity", o_joint_velocity, e.vel);
                if (o_motor_speed !== e.spd) report("motor_speed", o_motor_speed, e.spd);
                if (o_saturated !== e.sat) report("saturated", o_saturated, e.sat);
            end
        end
    end

    // a pending input word counts as outstanding work too
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n
                || (expected_q.size() == 0 && !i_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        errors = 0; idle_cycles = 0; stall_en = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b1;
        i_command = '0; i_joint = '0; i_start_pos = '0; i_mid_pos = '0; i_end_pos = '0;
        i_start_vel = '0; i_end_vel = '0; i_time_req = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        point_per = POINT_PERIOD_RST; via_per = VIA_PERIOD_RST;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_extremes();
        stall_en = 1'b1;
        test_periods();
        test_random_traffic();
        if (errors == 0 && expected_q.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
src/cubv_pkg.sv
src/cubv_front.sv
src/cubv_poly.sv
src/cubv_div.sv
src/cubv_out.sv
src/cubic_trajectory_velocity.sv
tb/sv/tb.sv
